>>> rtl/ebwr_pkg.sv
package ebwr_pkg;

   localparam int AngleWidth = 16;
   localparam int VelWidth = 16;
   localparam int CordicWidth = 36;
   localparam int AtanSteps = 24;
   localparam int TrigIterationsDefault = 14;

   localparam logic signed [CordicWidth-1:0] CordicGain = 36'sd652032874;
   localparam logic signed [CordicWidth-1:0] PiQ30 = 36'sd3373259426;
   localparam logic signed [CordicWidth-1:0] HalfPiQ30 = 36'sd1686629713;

   // Arctangent of 2^-i in Q2.30 radians.
   function automatic logic signed [CordicWidth-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CordicWidth-1:0] r;
      case (idx)
         5'd0: r = 36'sd843314857;
         5'd1: r = 36'sd497837829;
         5'd2: r = 36'sd263043837;
         5'd3: r = 36'sd133525159;
         5'd4: r = 36'sd67021688;
         5'd5: r = 36'sd33543516;
         5'd6: r = 36'sd16775851;
         5'd7: r = 36'sd8388437;
         5'd8: r = 36'sd4194283;
         5'd9: r = 36'sd2097149;
         default: r = CordicWidth'(36'sd1 <<< (30 - idx));
      endcase
      return r;
   endfunction

   // One angle's worth of CORDIC state; each cell carries three of these from cell to cell.
   typedef struct packed {
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [CordicWidth-1:0] z;
      logic                          flip;
   } rot_type;

   typedef struct packed {
      logic                         valid;
      rot_type [2:0]                rot;
      logic signed [VelWidth-1:0]   vx;
      logic signed [VelWidth-1:0]   vy;
      logic signed [VelWidth-1:0]   vz;
   } cell_type;

endpackage

>>> rtl/ebwr_cordic_cell.sv
// One CORDIC step applied to roll, pitch and yaw at once, one register deep.
module ebwr_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ebwr_pkg::cell_type cell_in,
   output ebwr_pkg::cell_type cell_out
);

   localparam logic [4:0] StepIdx = 5'(STEP);
   localparam logic signed [ebwr_pkg::CordicWidth-1:0] AtanStep =
      ebwr_pkg::atan_q30(StepIdx);

   ebwr_pkg::cell_type cell_ff;
   ebwr_pkg::cell_type cell_in_next;

   // Rotate each angle one step toward zero residual.
   always_comb begin
      cell_in_next = cell_in;
      for (int a = 0; a < 3; a++) begin
         if (!cell_in.rot[a].z[ebwr_pkg::CordicWidth-1]) begin
            cell_in_next.rot[a].x = cell_in.rot[a].x - (cell_in.rot[a].y >>> STEP);
            cell_in_next.rot[a].y = cell_in.rot[a].y + (cell_in.rot[a].x >>> STEP);
            cell_in_next.rot[a].z = cell_in.rot[a].z - AtanStep;
         end else begin
            cell_in_next.rot[a].x = cell_in.rot[a].x + (cell_in.rot[a].y >>> STEP);
            cell_in_next.rot[a].y = cell_in.rot[a].y - (cell_in.rot[a].x >>> STEP);
            cell_in_next.rot[a].z = cell_in.rot[a].z + AtanStep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (advance) begin
         cell_ff.rot <= cell_in_next.rot;
         cell_ff.vx  <= cell_in.vx;
         cell_ff.vy  <= cell_in.vy;
         cell_ff.vz  <= cell_in.vz;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/ebwr_matrix.sv
// Rounds sine and cosine, builds the rotation matrix and applies it to the
// velocity over five register stages.
module ebwr_matrix (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  ebwr_pkg::cell_type         cell_in,
   output logic                       valid_out,
   output logic signed [15:0]         world_x,
   output logic signed [15:0]         world_y,
   output logic signed [15:0]         world_z
);

   // Stage 1: cos/sin in Q1.15 (18 bits signed to hold +1.0 and rounding).
   logic        valid1_ff;
   logic signed [17:0] cs_ff [3];
   logic signed [17:0] sn_ff [3];
   logic signed [15:0] v1_ff [3];
   logic signed [17:0] cs_in [3];
   logic signed [17:0] sn_in [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [ebwr_pkg::CordicWidth-1:0] xf, yf, xr, yr;
         xf = cell_in.rot[a].flip ? -cell_in.rot[a].x : cell_in.rot[a].x;
         yf = cell_in.rot[a].flip ? -cell_in.rot[a].y : cell_in.rot[a].y;
         xr = (xf + 36'sd16384) >>> 15;
         yr = (yf + 36'sd16384) >>> 15;
         cs_in[a] = xr[17:0];
         sn_in[a] = yr[17:0];
      end
   end

   // Stage 2: two-factor products (Q.30).
   logic        valid2_ff;
   logic signed [35:0] cysp_ff, sycr_ff, sysr_ff, cycr_ff, spsy_ff;
   logic signed [35:0] cycp_ff, sycp_ff, srcp_ff, crcp_ff, cysr_ff;
   logic signed [17:0] sr2_ff, cr2_ff, sp2_ff;
   logic signed [15:0] v2_ff [3];

   // Stage 3: matrix entries in Q.30.
   logic        valid3_ff;
   logic signed [35:0] m_ff [9];
   logic signed [15:0] v3_ff [3];
   logic signed [53:0] t01, t02, t11, t12;

   always_comb begin
      t01 = 54'(cysp_ff) * 54'(sr2_ff) - (54'(sycr_ff) <<< 15);
      t02 = 54'(cysp_ff) * 54'(cr2_ff) + (54'(sysr_ff) <<< 15);
      t11 = 54'(spsy_ff) * 54'(sr2_ff) + (54'(cycr_ff) <<< 15);
      t12 = 54'(spsy_ff) * 54'(cr2_ff) - (54'(cysr_ff) <<< 15);
   end

   // Stage 4: products with velocity; stage 5: sums, rounding, saturation.
   logic        valid4_ff;
   logic signed [53:0] p_ff [9];
   logic        valid5_ff;
   logic signed [15:0] w_ff [3];
   logic signed [55:0] acc [3];
   logic signed [55:0] rnd [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = 56'(p_ff[3*r]) + 56'(p_ff[3*r+1]) + 56'(p_ff[3*r+2]);
         rnd[r] = (acc[r] + (56'sd1 <<< 29)) >>> 30;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= cell_in.valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
      if (advance) begin
         cs_ff <= cs_in;
         sn_ff <= sn_in;
         v1_ff[0] <= cell_in.vx;
         v1_ff[1] <= cell_in.vy;
         v1_ff[2] <= cell_in.vz;
         // index 0 roll, 1 pitch, 2 yaw
         cysp_ff <= 36'(cs_ff[2] * sn_ff[1]);
         sycr_ff <= 36'(sn_ff[2] * cs_ff[0]);
         sysr_ff <= 36'(sn_ff[2] * sn_ff[0]);
         cycr_ff <= 36'(cs_ff[2] * cs_ff[0]);
         spsy_ff <= 36'(sn_ff[1] * sn_ff[2]);
         cysr_ff <= 36'(cs_ff[2] * sn_ff[0]);
         cycp_ff <= 36'(cs_ff[2] * cs_ff[1]);
         sycp_ff <= 36'(sn_ff[2] * cs_ff[1]);
         srcp_ff <= 36'(sn_ff[0] * cs_ff[1]);
         crcp_ff <= 36'(cs_ff[0] * cs_ff[1]);
         sr2_ff <= sn_ff[0];
         cr2_ff <= cs_ff[0];
         sp2_ff <= sn_ff[1];
         v2_ff <= v1_ff;
         m_ff[0] <= cycp_ff;
         m_ff[1] <= 36'((t01 + 54'sd16384) >>> 15);
         m_ff[2] <= 36'((t02 + 54'sd16384) >>> 15);
         m_ff[3] <= sycp_ff;
         m_ff[4] <= 36'((t11 + 54'sd16384) >>> 15);
         m_ff[5] <= 36'((t12 + 54'sd16384) >>> 15);
         m_ff[6] <= -(36'(sp2_ff) <<< 15);
         m_ff[7] <= srcp_ff;
         m_ff[8] <= crcp_ff;
         v3_ff <= v2_ff;
         for (int k = 0; k < 9; k++) begin
            p_ff[k] <= 54'(m_ff[k]) * 54'(v3_ff[k % 3]);
         end
         for (int r = 0; r < 3; r++) begin
            if (rnd[r] > 56'sd32767) begin
               w_ff[r] <= 16'sh7fff;
            end else if (rnd[r] < -56'sd32768) begin
               w_ff[r] <= -16'sh8000;
            end else begin
               w_ff[r] <= rnd[r][15:0];
            end
         end
      end
   end

   assign valid_out = valid5_ff;
   assign world_x = w_ff[0];
   assign world_y = w_ff[1];
   assign world_z = w_ff[2];

endmodule

>>> rtl/euler_body_to_world_rotate.sv
// Rotates a body-frame velocity into the world frame with the Z-Y-X Euler
// matrix. Sine and cosine of all three angles come from a row of
// TRIG_ITERATIONS CORDIC cells (capped at AtanSteps), one step per cell,
// followed by five matrix stages and the output register. One transaction is
// accepted every cycle; the whole pipeline stalls together only when the
// output register is full and not taken.
module euler_body_to_world_rotate #(
   parameter int TRIG_ITERATIONS = ebwr_pkg::TrigIterationsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // roll_angle, pitch_angle, yaw_angle, body_vel_x, body_vel_y, body_vel_z
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // world_vel_x, world_vel_y, world_vel_z
   output logic [47:0] rsp_tdata
);

   localparam int Steps = (TRIG_ITERATIONS > ebwr_pkg::AtanSteps) ?
                          ebwr_pkg::AtanSteps : TRIG_ITERATIONS;

   logic advance;
   logic mat_valid;
   logic signed [15:0] wx, wy, wz;
   logic out_valid_ff;
   logic [47:0] out_data_ff;
   ebwr_pkg::cell_type head;
   ebwr_pkg::cell_type chain [Steps+1];

   // Pipeline moves whenever the output register is free or being taken.
   assign advance = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Widen angles to Q2.30 and fold into +-pi/2.
   always_comb begin
      head.valid = req_tvalid;
      for (int a = 0; a < 3; a++) begin
         logic signed [ebwr_pkg::CordicWidth-1:0] z;
         z = ebwr_pkg::CordicWidth'($signed(req_tdata[16*a +: 16])) <<< 17;
         head.rot[a].x = ebwr_pkg::CordicGain;
         head.rot[a].y = '0;
         head.rot[a].flip = 1'b0;
         head.rot[a].z = z;
         if (z > ebwr_pkg::HalfPiQ30) begin
            head.rot[a].z = z - ebwr_pkg::PiQ30;
            head.rot[a].flip = 1'b1;
         end else if (z < -ebwr_pkg::HalfPiQ30) begin
            head.rot[a].z = z + ebwr_pkg::PiQ30;
            head.rot[a].flip = 1'b1;
         end
      end
      head.vx = $signed(req_tdata[63:48]);
      head.vy = $signed(req_tdata[79:64]);
      head.vz = $signed(req_tdata[95:80]);
   end

   assign chain[0] = head;

   for (genvar i = 0; i < Steps; i++) begin : g_cell
      ebwr_cordic_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   ebwr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cell_in   (chain[Steps]),
      .valid_out (mat_valid),
      .world_x   (wx),
      .world_y   (wy),
      .world_z   (wz)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= mat_valid;
      end
      if (advance) begin
         out_data_ff <= {wz, wy, wx};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

   // A waiting result holds its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Input is taken exactly when the output side can move.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");

endmodule
